@@ rtl/stid_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// stid_pkg: shared types and constants for the sorted table
// Holds the table depth, operation and status codes and the cell link types.
// ============================================================================
package stid_pkg;

    localparam int DEPTH   = 8;
    localparam int VAL_W   = 32;
    localparam int IDX_W   = 3;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SLOT_W  = $clog2(DEPTH);

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_READ   = 2'd2,
        KIND_NOP    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    // operation broadcast to every cell
    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic signed [VAL_W-1:0] value;
    } t_cell_op;

    // contents handed between neighboring cells
    typedef struct packed {
        logic                    valid;
        logic signed [VAL_W-1:0] entry;
    } t_cell_data;

    // per-cell flags reported to the top level
    typedef struct packed {
        logic lt;
        logic is_pos;
        logic hit;
    } t_cell_flags;

endpackage

@@ rtl/stid_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// stid_if: request and response channels
// Valid/ready channels carrying one table operation and one result.
// ============================================================================
interface stid_in_if;
    import stid_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [1:0]              kind;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        index;

    modport source (output valid, output kind, output value, output index, input ready);
    modport sink   (input valid, input kind, input value, input index, output ready);
endinterface

interface stid_out_if;
    import stid_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic signed [VAL_W-1:0] result_value;
    logic [CNT_W-1:0]        position;
    logic [CNT_W-1:0]        entry_count;

    modport source (output valid, output status, output result_value, output position,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input result_value, input position,
                    input entry_count, output ready);
endinterface

@@ rtl/stid_cell.sv @@
`timescale 1ns / 1ps
// ============================================================================
// stid_cell: one slot of the sorted table
// Holds one entry; on insert takes the new value or the left neighbor's
// entry, on delete takes the right neighbor's entry.
// ============================================================================
module stid_cell
    import stid_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cell_op    i_op,
    input  t_cell_data  i_left,
    input  logic        i_left_lt,
    input  t_cell_data  i_right,
    output t_cell_data  o_data,
    output t_cell_flags o_flags
);

    logic                    r_valid;
    logic signed [VAL_W-1:0] r_entry;
    logic                    n_valid;
    logic signed [VAL_W-1:0] n_entry;
    logic                    lt;
    logic                    is_pos;

    // entries are sorted, so lt forms a prefix; the first clear one is the slot
    assign lt     = r_valid && (r_entry < i_op.value);
    assign is_pos = !lt && i_left_lt;

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_op.ins && !lt) begin
            if (is_pos) begin
                n_valid = 1'b1;
                n_entry = i_op.value;
            end else begin
                n_valid = i_left.valid;
                n_entry = i_left.entry;
            end
        end else if (i_op.del && !lt) begin
            n_valid = i_right.valid;
            n_entry = i_right.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_entry <= n_entry;
    end

    assign o_data.valid   = r_valid;
    assign o_data.entry   = r_entry;
    assign o_flags.lt     = lt;
    assign o_flags.is_pos = is_pos;
    assign o_flags.hit    = is_pos && r_valid && (r_entry == i_op.value);

endmodule

@@ rtl/sorted_table_insert_delete.sv @@
`timescale 1ns / 1ps
// ============================================================================
// sorted_table_insert_delete: ascending table with insert, delete and read
// A row of DEPTH cells keeps signed values in order; each transaction is
// one operation and returns one result.
// ============================================================================
//
//  Channel | Direction | Payload
//  --------+-----------+-------------------------------------------------
//  i_in    | in        | kind, value, index
//  o_out   | out       | status, result_value, position, entry_count
//
//  One transaction per cycle while the output register is free or drains:
//  every cell compares against the broadcast value and shifts, so the cell
//  row is updated at the same edge that takes the transaction. The result is
//  captured in an output register at that edge. A stalled output register holds i_in.ready low until taken.
//  Reset clears the count, all cell valid bits and the output valid.
//
module sorted_table_insert_delete
    import stid_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    stid_in_if.sink          i_in,
    stid_out_if.source       o_out
);

    t_cell_data  cell_data  [DEPTH];
    t_cell_flags cell_flags [DEPTH];
    t_cell_op    op;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic                    r_out_valid;
    t_status                 r_status;
    logic signed [VAL_W-1:0] r_result;
    logic [CNT_W-1:0]        r_position;
    logic [CNT_W-1:0]        r_entry_count;

    t_status                 n_status;
    logic signed [VAL_W-1:0] n_result;
    logic [CNT_W-1:0]        n_position;

    logic             accept;
    logic             full;
    logic             found;
    logic [CNT_W-1:0] slot_pos;
    logic [DEPTH-1:0] valid_vec;
    t_kind            kind;

    assign kind   = t_kind'(i_in.kind);
    assign accept = i_in.valid && i_in.ready;
    // take a new transaction whenever the output register is free or drains
    assign i_in.ready = !r_out_valid || o_out.ready;

    assign full = (r_count == CNT_W'(DEPTH));

    // gate the broadcast so refused operations leave the row untouched
    assign op.value = i_in.value;
    assign op.ins   = accept && (kind == KIND_INSERT) && !full;
    assign op.del   = accept && (kind == KIND_DELETE) && found;

    // build the cell row
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_data left_d;
        t_cell_data right_d;
        logic       left_lt;

        if (g == 0) begin : g_first
            assign left_d  = '0;
            assign left_lt = 1'b1;
        end else begin : g_mid
            assign left_d  = cell_data[g-1];
            assign left_lt = cell_flags[g-1].lt;
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_inner
            assign right_d = cell_data[g+1];
        end

        stid_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (op),
            .i_left  (left_d),
            .i_left_lt (left_lt),
            .i_right (right_d),
            .o_data  (cell_data[g]),
            .o_flags (cell_flags[g])
        );

        assign valid_vec[g] = cell_data[g].valid;
    end

    // encode the one-hot slot and collect the equal-match flag
    always_comb begin
        slot_pos = '0;
        found    = 1'b0;
        for (int k = 0; k < DEPTH; k++) begin
            if (cell_flags[k].is_pos) begin
                slot_pos = slot_pos | CNT_W'(k);
            end
            found = found | cell_flags[k].hit;
        end
    end

    // result of the transaction
    always_comb begin
        n_status   = ST_OK;
        n_result   = '0;
        n_position = '0;
        n_count    = r_count;
        unique case (kind)
            KIND_INSERT: begin
                n_result = i_in.value;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_position = slot_pos;
                    n_count    = r_count + CNT_W'(1);
                end
            end
            KIND_DELETE: begin
                n_result = i_in.value;
                if (!found) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    n_position = slot_pos;
                    n_count    = r_count - CNT_W'(1);
                end
            end
            KIND_READ: begin
                n_position = CNT_W'(i_in.index);
                if (CNT_W'(i_in.index) >= r_count) begin
                    n_status = ST_BAD_INDEX;
                end else begin
                    n_result = cell_data[SLOT_W'(i_in.index)].entry;
                end
            end
            default: begin
                // ignored code: report ok with the unchanged count
            end
        endcase
    end

    // advance count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_status      <= n_status;
            r_result      <= n_result;
            r_position    <= n_position;
            r_entry_count <= n_count;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_status;
    assign o_out.result_value = r_result;
    assign o_out.position     = r_position;
    assign o_out.entry_count  = r_entry_count;

`ifndef SYNTH
    // valid cells always number exactly the count
    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(valid_vec) == int'(r_count))
        else $error("cell valid bits disagree with count");

    // a granted insert grows the table by one
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        op.ins |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow count");

    // a refused operation leaves the count alone
    a_refused_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_status != ST_OK) |=> $stable(r_count))
        else $error("refused operation changed count");

    // the count never passes the depth
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("count beyond depth");
`endif

endmodule

@@ bench/sorted_table_insert_delete_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// sorted_table_insert_delete_test: self-checking bench for the sorted table
// Drives insert, delete, read and idle-kind operations through the request
// channel and follows the table contents in a scoreboard. Each returned
// result is matched against the scoreboard's expectation, field by field.
// The request and response sides pause at random in several phases.
// ============================================================================
module sorted_table_insert_delete_test;
    import stid_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1550;
    localparam int TAIL_CYCLES  = 10;

    // One expected response, in the widths of the response channel.
    typedef struct packed {
        t_status                 status;
        logic signed [VAL_W-1:0] value;
        logic [CNT_W-1:0]        position;
        logic [CNT_W-1:0]        count;
    } t_table_result;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of the ordered table plus the queue of responses
    // still owed by the block. note_request updates the mirror for one
    // accepted transaction; check_result retires the oldest expectation.
    // ------------------------------------------------------------------------
    class sorted_table_tracker;
        logic signed [VAL_W-1:0] slots [DEPTH];
        int                      fill;
        t_table_result           owed [$];
        int                      mismatches;
        int                      kind_seen [4];
        int                      status_seen [4];

        function new();
            fill       = 0;
            mismatches = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        function void note_request(t_kind kind, logic signed [VAL_W-1:0] value,
                                   logic [IDX_W-1:0] index);
            t_table_result r;
            int            pos;
            int            i;
            r.status   = ST_OK;
            r.value    = '0;
            r.position = '0;
            case (kind)
                KIND_INSERT: begin
                    r.value = value;
                    if (fill >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        // land in front of the first entry not below the value
                        pos = fill;
                        for (i = 0; i < fill; i++) begin
                            if (value <= slots[i]) begin
                                pos = i;
                                break;
                            end
                        end
                        for (i = fill; i > pos; i--) slots[i] = slots[i-1];
                        slots[pos] = value;
                        fill++;
                        r.position = CNT_W'(pos);
                    end
                end
                KIND_DELETE: begin
                    r.value = value;
                    pos = -1;
                    for (i = 0; i < fill; i++) begin
                        if (slots[i] == value) begin
                            pos = i;
                            break;
                        end
                    end
                    if (pos < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        for (i = pos; i + 1 < fill; i++) slots[i] = slots[i+1];
                        fill--;
                        r.position = CNT_W'(pos);
                    end
                end
                KIND_READ: begin
                    r.position = CNT_W'(index);
                    if (int'(index) >= fill) begin
                        r.status = ST_BAD_INDEX;
                    end else begin
                        r.value = slots[index];
                    end
                end
                default: ;
            endcase
            r.count = CNT_W'(fill);
            kind_seen[kind]++;
            status_seen[r.status]++;
            owed.push_back(r);
        endfunction

        function void check_result(logic [1:0] status, logic signed [VAL_W-1:0] value,
                                   logic [CNT_W-1:0] position, logic [CNT_W-1:0] count);
            t_table_result e;
            if (owed.size() == 0) begin
                $error("response with no request outstanding: status %0d value %0d",
                       status, value);
                mismatches++;
                return;
            end
            e = owed.pop_front();
            if (status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, status);
                mismatches++;
            end
            if (value !== e.value) begin
                $error("result_value: expected %0d, got %0d", e.value, value);
                mismatches++;
            end
            if (position !== e.position) begin
                $error("position: expected %0d, got %0d", e.position, position);
                mismatches++;
            end
            if (count !== e.count) begin
                $error("entry_count: expected %0d, got %0d", e.count, count);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    stid_in_if  in_if ();
    stid_out_if out_if ();

    sorted_table_insert_delete dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    sorted_table_tracker tracker;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  cycle_count;
    int                  accepted;

    // Pool with repeats and the extremes, so deletes hit and ties are common.
    logic signed [VAL_W-1:0] value_pool [12] = '{
        32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1, 32'sd1, 32'sd5,
        32'sd5, -32'sd5, 32'sd1000, -32'sd1000, 32'sh4000_0000, 32'shC000_0000
    };

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Watchdog: any hang ends the run as a failure.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses owed",
                     cycle_count, tracker.owed.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Response side: pick ready at the falling edge, stalling at the phase rate.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Retire a response at every rising edge that completes a transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            tracker.check_result(out_if.status, out_if.result_value,
                                 out_if.position, out_if.entry_count);
    end

    // Offer one operation: idle at the phase rate first, then hold valid and
    // the payload until the block takes it. Returns at the falling edge after
    // acceptance, so the caller either drives the next operation or drops
    // valid with a single assignment in that step.
    task automatic send_op(t_kind kind, logic signed [VAL_W-1:0] value,
                           logic [IDX_W-1:0] index);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.kind  <= kind;
        in_if.value <= value;
        in_if.index <= index;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        tracker.note_request(kind, value, index);
        accepted++;
        @(negedge i_clk);
    endtask

    // Hold off the request side until every owed response has come back.
    task automatic wait_for_drain();
        in_if.valid <= 1'b0;
        while (tracker.owed.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        if ($urandom_range(1) == 0)
            return value_pool[$urandom_range(11)];
        return $urandom;
    endfunction

    // Random operations. Alternate fill-leaning and drain-leaning stretches so
    // the table passes between empty and full many times; deletes mostly aim
    // at an entry that is present. Idle-kind operations do not count.
    task automatic run_random(int n, int send_pct, int recv_pct);
        int                      done;
        int                      r;
        int                      ins_w;
        t_kind                   kind;
        logic signed [VAL_W-1:0] value;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        done = 0;
        while (done < n) begin
            ins_w = ((done / 40) % 2 == 0) ? 55 : 25;
            r = $urandom_range(99);
            if (r < 2)
                kind = KIND_NOP;
            else if (r < 2 + ins_w)
                kind = KIND_INSERT;
            else if (r < 82)
                kind = KIND_DELETE;
            else
                kind = KIND_READ;
            if (kind == KIND_DELETE && tracker.fill > 0 && $urandom_range(99) < 70)
                value = tracker.slots[$urandom_range(tracker.fill - 1)];
            else
                value = pick_value();
            send_op(kind, value, IDX_W'($urandom_range(DEPTH - 1)));
            if (kind != KIND_NOP) done++;
            if (done == n / 2 && kind != KIND_NOP) wait_for_drain();
        end
        wait_for_drain();
    endtask

    initial begin
        tracker        = new();
        accepted       = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.kind     = KIND_NOP;
        in_if.value    = '0;
        in_if.index    = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty-table refusals and the idle kind first.
        send_op(KIND_READ, 32'sd0, 3'd0);
        send_op(KIND_DELETE, 32'sd5, 3'd0);
        send_op(KIND_NOP, 32'shDEAD_BEEF, 3'd5);
        // Extremes and ties: duplicates must land ahead of their equals.
        send_op(KIND_INSERT, 32'sd0, 3'd0);
        send_op(KIND_INSERT, 32'sh7FFF_FFFF, 3'd0);
        send_op(KIND_INSERT, 32'sh8000_0000, 3'd0);
        send_op(KIND_INSERT, -32'sd1, 3'd0);
        send_op(KIND_INSERT, 32'sd0, 3'd0);
        send_op(KIND_INSERT, 32'sh7FFF_FFFF, 3'd0);
        send_op(KIND_INSERT, 32'sh8000_0000, 3'd0);
        send_op(KIND_INSERT, 32'sd100, 3'd0);
        // Table is full now: this insert must be refused.
        send_op(KIND_INSERT, 32'sd7, 3'd0);
        for (int i = 0; i < DEPTH; i++) send_op(KIND_READ, 32'sd0, IDX_W'(i));
        // Delete the lowest of two equal entries, then a missing value.
        send_op(KIND_DELETE, 32'sd0, 3'd0);
        send_op(KIND_DELETE, 32'sd12345, 3'd0);
        // Last slot is now past the count.
        send_op(KIND_READ, 32'sd0, 3'd7);
        send_op(KIND_DELETE, 32'sh8000_0000, 3'd0);
        wait_for_drain();

        // Random phases: free flow, sparse requests, slow sink, light both.
        run_random(RANDOM_ITEMS / 4, 0, 0);
        run_random(RANDOM_ITEMS / 4, 75, 0);
        run_random(RANDOM_ITEMS / 4, 0, 75);
        run_random(RANDOM_ITEMS - 3 * (RANDOM_ITEMS / 4), 16, 16);

        // Let any stray response show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d transactions: %0d inserts, %0d deletes, %0d reads, %0d idle kind.",
                 accepted, tracker.kind_seen[KIND_INSERT], tracker.kind_seen[KIND_DELETE],
                 tracker.kind_seen[KIND_READ], tracker.kind_seen[KIND_NOP]);
        $display("Refusals seen: %0d full inserts, %0d missing deletes, %0d reads past count.",
                 tracker.status_seen[ST_FULL], tracker.status_seen[ST_NOT_FOUND],
                 tracker.status_seen[ST_BAD_INDEX]);
        if (tracker.mismatches == 0 && tracker.owed.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ sorted_table_insert_delete.f @@
rtl/stid_pkg.sv
rtl/stid_if.sv
rtl/stid_cell.sv
rtl/sorted_table_insert_delete.sv
bench/sorted_table_insert_delete_test.sv
